// ===== rtl/lfcb_pkg.sv =====
`default_nettype none

package lfcb_pkg;

  localparam int PIX_W    = 8;
  localparam int TAP_W    = 16;
  localparam int RAD_W    = 3;
  localparam int NUM_TAPS = 8;
  localparam int COEF_W   = NUM_TAPS * TAP_W;

  // newest-sample index saturates here; beyond it the border logic is shift invariant
  localparam int SPOS_W   = 4;
  localparam int SPOS_MAX = 15;

  // configuration register map
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_LOW    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_HIGH   = 8'd3;

  // one output job handed from the front to the back
  typedef struct packed {
    logic [RAD_W-1:0]  k;     // distance from newest sample to the center sample
    logic [SPOS_W-1:0] s_c;   // saturated index of the newest sample in its line
    logic [RAD_W-1:0]  r;     // effective radius
    logic              mode;  // 1 mirror reflection
    logic              last;
    logic              err;
  } lfcb_job_t;

endpackage

`default_nettype wire

// ===== rtl/lfcb_queue.sv =====
`default_nettype none

module lfcb_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfcb_front.sv =====
`default_nettype none

module lfcb_front import lfcb_pkg::*; #(
  parameter int MAX_RADIUS = 7,
  parameter int MAX_LINE   = 4096,
  localparam int WIN       = 2 * MAX_RADIUS + 1,
  localparam int PW        = $clog2(MAX_LINE)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [PIX_W-1:0]   in_pixel,
  input  wire logic               in_line_end,
  input  wire logic [RAD_W-1:0]   radius,
  input  wire logic               border_mode,
  input  wire logic               q_full,
  output logic                    q_push,
  output logic [WIN*PIX_W-1:0]    q_win,
  output lfcb_job_t               q_job
);

  logic [PIX_W-1:0]  win_r [WIN];
  logic [PIX_W-1:0]  win_nxt [WIN];
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              fl_act_r, fl_act_nxt;
  logic [RAD_W-1:0]  fl_k_r, fl_k_nxt;
  lfcb_job_t         fl_job_r, fl_job_nxt;

  logic              accept;
  logic [RAD_W-1:0]  r_eff;
  logic [SPOS_W-1:0] s_c;
  logic [RAD_W-1:0]  k_start;
  logic              short_err;

  // flush owns the queue port until the last result of the line is pushed
  assign in_stall = fl_act_r || q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    r_eff     = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
    s_c       = (pos_r >= PW'(SPOS_MAX)) ? SPOS_W'(SPOS_MAX) : pos_r[SPOS_W-1:0];
    k_start   = (s_c < SPOS_W'(r_eff)) ? s_c[RAD_W-1:0] : r_eff;
    short_err = border_mode && ((5'(s_c) + 5'd1) < 5'(r_eff));

    win_nxt    = win_r;
    pos_nxt    = pos_r;
    fl_act_nxt = fl_act_r;
    fl_k_nxt   = fl_k_r;
    fl_job_nxt = fl_job_r;
    q_push     = 1'b0;
    q_job      = '0;

    if (fl_act_r) begin
      q_job      = fl_job_r;
      q_job.k    = fl_k_r;
      q_job.last = (fl_k_r == '0);
      if (!q_full) begin
        q_push = 1'b1;
        if (fl_k_r == '0) begin
          fl_act_nxt = 1'b0;
        end else begin
          fl_k_nxt = fl_k_r - RAD_W'(1);
        end
      end
    end else if (accept) begin
      win_nxt[0] = in_pixel;
      for (int i = 1; i < WIN; i++) begin
        win_nxt[i] = win_r[i-1];
      end
      q_job.s_c  = s_c;
      q_job.r    = r_eff;
      q_job.mode = border_mode;
      if (!in_line_end) begin
        q_job.k    = r_eff;
        q_job.last = 1'b0;
        q_job.err  = 1'b0;
        q_push     = (s_c >= SPOS_W'(r_eff));
        pos_nxt    = (pos_r == PW'(MAX_LINE - 1)) ? pos_r : pos_r + PW'(1);
      end else begin
        q_job.k    = k_start;
        q_job.last = (k_start == '0);
        q_job.err  = short_err;
        q_push     = 1'b1;
        pos_nxt    = '0;
        fl_job_nxt = q_job;
        fl_k_nxt   = k_start - RAD_W'(1);
        fl_act_nxt = (k_start != '0);
      end
    end

    for (int i = 0; i < WIN; i++) begin
      q_win[PIX_W*i +: PIX_W] = win_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fl_act_r <= 1'b0;
      fl_k_r   <= '0;
      for (int i = 0; i < WIN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      pos_r    <= pos_nxt;
      fl_act_r <= fl_act_nxt;
      fl_k_r   <= fl_k_nxt;
      win_r    <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fl_job_r <= fl_job_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/lfcb_back.sv =====
`default_nettype none

module lfcb_back import lfcb_pkg::*; #(
  parameter int MAX_RADIUS     = 7,
  parameter int COEF_FRAC_BITS = 15,
  localparam int WIN           = 2 * MAX_RADIUS + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [COEF_W-1:0]     coef,
  input  wire logic                  q_empty,
  input  wire logic [WIN*PIX_W-1:0]  q_win,
  input  wire lfcb_job_t             q_job,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           out_filtered,
  output logic                       out_last,
  output logic                       out_border_error
);

  localparam int NT       = MAX_RADIUS + 1;
  localparam int IW       = $clog2(WIN);
  localparam int PSUM_W   = PIX_W + 1;
  localparam int PROD_W   = PSUM_W + TAP_W;
  localparam int ACC_W    = PROD_W + $clog2(NT);
  localparam int RND_W    = ACC_W + 1;
  localparam int RND_HALF = 1 << (COEF_FRAC_BITS - 1);
  localparam logic signed [6:0] WIN_S = 7'(WIN);

  // sample at offset d from the center, with the border folded in
  function automatic logic [PIX_W-1:0] fetch(
    input logic [WIN*PIX_W-1:0] w,
    input logic [SPOS_W-1:0]    s,
    input logic [RAD_W-1:0]     k,
    input logic signed [4:0]    d,
    input logic                 mode
  );
    logic signed [6:0] ss, kk, dd, q, len, idx;
    logic              hit;
    ss  = {3'b000, s};
    kk  = {4'b0000, k};
    dd  = d;
    q   = ss - kk + dd;
    len = ss + 7'sd1;
    hit = 1'b1;
    if (q < 7'sd0) begin
      if (!mode) hit = 1'b0;
      q = -q - 7'sd1;
    end
    if (q >= len) begin
      if (!mode) hit = 1'b0;
      q = (len <<< 1) - 7'sd1 - q;
    end
    if (q < 7'sd0 || q >= len) hit = 1'b0;
    idx = ss - q;
    if (idx < 7'sd0 || idx >= WIN_S) hit = 1'b0;
    fetch = hit ? w[PIX_W*idx[IW-1:0] +: PIX_W] : '0;
  endfunction

  logic                en;
  logic                v1_r, v2_r, v3_r, out_valid_r;
  logic                l1_r, l2_r, l3_r, e1_r, e2_r, e3_r;
  logic [PIX_W-1:0]    fp [NT];
  logic [PIX_W-1:0]    fm [NT];
  logic [PSUM_W-1:0]   psum_nxt [NT];
  logic [PSUM_W-1:0]   psum_r [NT];
  logic [PROD_W-1:0]   prod_nxt [NT];
  logic [PROD_W-1:0]   prod_r [NT];
  logic [ACC_W-1:0]    acc_nxt, acc_r;
  logic [RND_W-1:0]    rnd, shifted;
  logic [PIX_W-1:0]    filt_nxt, filt_r;
  logic                last_r, err_r;

  // whole pipe advances when the output register is free or being drained
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_empty;

  // stage 1: border fetch and symmetric pre-add
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      fp[i] = fetch(q_win, q_job.s_c, q_job.k, 5'(i), q_job.mode);
      fm[i] = fetch(q_win, q_job.s_c, q_job.k, 5'(-i), q_job.mode);
      if (RAD_W'(i) > q_job.r) begin
        psum_nxt[i] = '0;
      end else if (i == 0) begin
        psum_nxt[i] = PSUM_W'(fp[i]);
      end else begin
        psum_nxt[i] = PSUM_W'(fp[i]) + PSUM_W'(fm[i]);
      end
    end
  end

  // stage 2: one multiplier per tap
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      prod_nxt[i] = PROD_W'(psum_r[i]) * PROD_W'(coef[TAP_W*i +: TAP_W]);
    end
  end

  // stage 3: sum of products
  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < NT; i++) begin
      acc_nxt = acc_nxt + ACC_W'(prod_r[i]);
    end
  end

  // stage 4: round half up and clamp
  always_comb begin
    rnd      = RND_W'(acc_r) + RND_W'(RND_HALF);
    shifted  = rnd >> COEF_FRAC_BITS;
    filt_nxt = (shifted > RND_W'(255)) ? 8'hFF : shifted[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= !q_empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psum_r <= psum_nxt;
      l1_r   <= q_job.last;
      e1_r   <= q_job.err;
      prod_r <= prod_nxt;
      l2_r   <= l1_r;
      e2_r   <= e1_r;
      acc_r  <= acc_nxt;
      l3_r   <= l2_r;
      e3_r   <= e2_r;
      filt_r <= filt_nxt;
      last_r <= l3_r;
      err_r  <= e3_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filtered     = filt_r;
  assign out_last         = last_r;
  assign out_border_error = err_r;

endmodule

`default_nettype wire

// ===== rtl/line_fir_convolution_border.sv =====
`default_nettype none

// Symmetric 1-D FIR over one line of 8-bit pixels, up to 2*MAX_RADIUS+1 taps with
// unsigned Q1.COEF_FRAC_BITS coefficients, zero or mirror (edge-repeating) border,
// round half up and clamp to 0..255. One pixel is taken per clock while not stalled.
// A result for pixel p leaves once pixel p+radius has been taken; the pixel marked
// line_end releases all pending results of the line, the final one flagged last, and
// the input stalls while the line front pushes those flush jobs one per clock into
// the job queue, as long as it is not full. In mirror mode a line shorter than radius
// sets border_error on all its results. The queue is written at the accepting edge;
// a job then passes the fetch/pre-add, multiply, sum and round/clamp register stages.
// The user writes configuration only while the block is idle; it is not enforced.
module line_fir_convolution_border import lfcb_pkg::*; #(
  parameter int MAX_RADIUS     = 7,
  parameter int MAX_LINE       = 4096,
  parameter int COEF_FRAC_BITS = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // pixel input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     in_pixel,
  input  wire logic                 in_line_end,
  // filtered output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PIX_W-1:0]          out_filtered,
  output logic                      out_last,
  output logic                      out_border_error,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int WIN_W = WIN * PIX_W;
  localparam int JOB_W = $bits(lfcb_job_t);
  localparam int QW    = WIN_W + JOB_W;

  // configuration registers
  logic [RAD_W-1:0]     radius_r;
  logic                 border_mode_r;
  logic [CFG_DAT_W-1:0] taps_low_r, taps_high_r;

  // front to queue
  logic                 fr_push;
  logic [WIN_W-1:0]     fr_win;
  lfcb_job_t            fr_job;
  logic                 q_full, q_empty, q_pop;
  logic [QW-1:0]        q_rdata;
  logic [WIN_W-1:0]     bk_win;
  lfcb_job_t            bk_job;

  // writes are never held off
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= RAD_W'(1);
      border_mode_r <= 1'b0;
      taps_low_r    <= '0;
      taps_high_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIUS:      radius_r      <= cfg_data[RAD_W-1:0];
        CFG_BORDER_MODE: border_mode_r <= cfg_data[0];
        CFG_TAPS_LOW:    taps_low_r    <= cfg_data;
        CFG_TAPS_HIGH:   taps_high_r   <= cfg_data;
        default: begin
          // unmapped index, transfer is dropped
        end
      endcase
    end
  end

  // line front: window shift, position tracking, flush sequencing
  lfcb_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_LINE   (MAX_LINE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel    (in_pixel),
    .in_line_end (in_line_end),
    .radius      (radius_r),
    .border_mode (border_mode_r),
    .q_full      (q_full),
    .q_push      (fr_push),
    .q_win       (fr_win),
    .q_job       (fr_job)
  );

  // two-entry job queue: window snapshot plus job descriptor
  lfcb_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .wdata ({fr_win, fr_job}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign bk_win = q_rdata[QW-1:JOB_W];
  assign bk_job = q_rdata[JOB_W-1:0];

  // arithmetic back end: border fetch, pre-add, multiply, sum, round
  lfcb_back #(
    .MAX_RADIUS     (MAX_RADIUS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .coef             ({taps_high_r, taps_low_r}),
    .q_empty          (q_empty),
    .q_win            (bk_win),
    .q_job            (bk_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_last         (out_last),
    .out_border_error (out_border_error)
  );

endmodule

`default_nettype wire

// ===== verif/line_fir_convolution_border_checker.sv =====
`default_nettype none

module line_fir_convolution_border_checker import lfcb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [PIX_W-1:0]     in_pixel,
  input  wire logic                 in_line_end,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [PIX_W-1:0]     out_filtered,
  input  wire logic                 out_last,
  input  wire logic                 out_border_error,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        px_owed
);

  localparam int MAX_RADIUS = 7;
  localparam int MAX_LINE   = 4096;
  localparam int FRAC_BITS  = 15;
  localparam int WIN        = 2 * MAX_RADIUS + 1;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             last;
    logic             border_error;
  } blur_px_t;

  logic [RAD_W-1:0]     radius_q;
  logic                 mirror_q;
  logic [CFG_DAT_W-1:0] taps_lo_q;
  logic [CFG_DAT_W-1:0] taps_hi_q;
  logic [PIX_W-1:0]     line_win [WIN];
  int                   line_pos;
  int                   fail_tally = 0;
  blur_px_t             owed_px [$];

  initial begin
    fail_count = 0;
    px_owed    = 0;
  end

  function automatic logic [31:0] tap_coef(int d);
    if (d < 0) d = -d;
    if (d < 4) return 32'(taps_lo_q[16*d +: 16]);
    return 32'(taps_hi_q[16*(d-4) +: 16]);
  endfunction

  // sample at line index q; newest is the index of window entry 0
  function automatic logic [31:0] border_sample(int q, int newest, int len);
    int d;
    if (q < 0) begin
      if (!mirror_q) return 0;
      q = -q - 1;
    end
    if (q >= len) begin
      if (!mirror_q) return 0;
      q = 2 * len - 1 - q;
    end
    if (q < 0 || q >= len) return 0;
    d = newest - q;
    if (d < 0 || d >= WIN) return 0;
    return 32'(line_win[d]);
  endfunction

  function automatic logic [PIX_W-1:0] blurred_px(int p, int newest, int len, int r);
    logic [31:0] acc;
    logic [31:0] sum;
    acc = 0;
    for (int d = -r; d <= r; d++)
      acc += border_sample(p + d, newest, len) * tap_coef(d);
    sum = (acc + (32'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (sum > 32'd255) ? 8'hFF : sum[PIX_W-1:0];
  endfunction

  // append one expected result at the tail
  task automatic owe_px(blur_px_t px);
    owed_px.insert(owed_px.size(), px);
  endtask

  task automatic take_pixel(logic [PIX_W-1:0] px, logic line_end);
    int   newest;
    int   r;
    int   len;
    int   p;
    logic short_err;
    newest = line_pos;
    r      = int'(radius_q);
    len    = newest + 1;
    for (int i = WIN - 1; i > 0; i--) line_win[i] = line_win[i-1];
    line_win[0] = px;
    if (!line_end) begin
      if (newest >= r) owe_px('{blurred_px(newest - r, newest, len, r), 1'b0, 1'b0});
      line_pos = (newest + 1 > MAX_LINE - 1) ? MAX_LINE - 1 : newest + 1;
    end else begin
      // flush everything still pending for this line
      short_err = mirror_q && (len < r);
      for (p = (newest - r < 0) ? 0 : newest - r; p <= newest; p++)
        owe_px('{blurred_px(p, newest, len, r), p == newest, short_err});
      line_pos = 0;
    end
  endtask

  task automatic report_mismatch(string msg);
    fail_tally++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result;
    blur_px_t want;
    if (owed_px.size() == 0) begin
      report_mismatch($sformatf("result with nothing owed: filtered=%0d last=%0b err=%0b",
                                out_filtered, out_last, out_border_error));
      return;
    end
    want = owed_px.pop_front();
    if (out_filtered !== want.filtered)
      report_mismatch($sformatf("filtered %0d, want %0d", out_filtered, want.filtered));
    if (out_last !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
    if (out_border_error !== want.border_error)
      report_mismatch($sformatf("border_error %0b, want %0b",
                                out_border_error, want.border_error));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      radius_q  = 3'd1;
      mirror_q  = 1'b0;
      taps_lo_q = '0;
      taps_hi_q = '0;
      for (int i = 0; i < WIN; i++) line_win[i] = '0;
      line_pos  = 0;
      owed_px.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIUS:      radius_q  = cfg_data[RAD_W-1:0];
          CFG_BORDER_MODE: mirror_q  = cfg_data[0];
          CFG_TAPS_LOW:    taps_lo_q = cfg_data;
          CFG_TAPS_HIGH:   taps_hi_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_pixel(in_pixel, in_line_end);
      if (out_valid && !out_stall) check_result();
    end
    fail_count <= fail_tally;
    px_owed    <= owed_px.size();
  end

endmodule

`default_nettype wire

// ===== verif/line_fir_convolution_border_tb.sv =====
`default_nettype none

module line_fir_convolution_border_tb;
  import lfcb_pkg::*;

  localparam int LIMIT        = 800000;  // cycle budget for the whole run
  localparam int SETTLE       = 16;      // pipeline depth plus margin
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int RANDOM_ITEMS = 390;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_TAPS_HIGH + CFG_IDX_W'(1);  // first unmapped

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_style_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 in_line_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_filtered;
  logic                 out_last;
  logic                 out_border_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count;
  int px_owed;
  int cycles = 0;

  // sender pacing: bursts of random length, gaps up to gap_max (0 means no idling)
  int burst_left = 0;
  int gap_max = 0;
  // set once by the stimulus to make the receiver hold off
  logic hold_off_req = 1'b0;

  always #5 clk = ~clk;

  line_fir_convolution_border dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .in_line_end      (in_line_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_last         (out_last),
    .out_border_error (out_border_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  line_fir_convolution_border_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .in_line_end      (in_line_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_last         (out_last),
    .out_border_error (out_border_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .px_owed          (px_owed)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** line_fir_convolution_border: FAILED **");
      $finish;
    end
  end

  // receiver: randomly chosen stall patterns, plus one long hold-off
  initial begin
    rx_style_t style;
    int        left;
    style = RX_OPEN;
    left  = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        // sender keeps offering pixels meanwhile, so the block backs up into in_stall
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          style = rx_style_t'($urandom_range(0, 3));
          left  = $urandom_range(16, 96);
        end
        left--;
        case (style)
          RX_OPEN:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
          default:  out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // one pixel transfer; valid stays high across a burst
  task automatic send_px(input logic [PIX_W-1:0] px, input logic line_end);
    int gap;
    if (gap_max > 0 && burst_left <= 0) begin
      gap = $urandom_range(1, gap_max);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid    <= 1'b1;
    in_pixel    <= px;
    in_line_end <= line_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // pixels lean toward the rails now and then
  function automatic logic [PIX_W-1:0] rand_px();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) send_px(rand_px(), i == len - 1);
  endtask

  // stop sending and wait until every owed result has left, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (px_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // junk in the unused upper bits of the narrow registers
  task automatic setup(input logic [RAD_W-1:0] r, input logic mirror,
                       input logic [CFG_DAT_W-1:0] lo, input logic [CFG_DAT_W-1:0] hi);
    logic [CFG_DAT_W-1:0] word;
    word = {$urandom, $urandom};
    word[RAD_W-1:0] = r;
    write_reg(CFG_RADIUS, word);
    word = {$urandom, $urandom};
    word[0] = mirror;
    write_reg(CFG_BORDER_MODE, word);
    write_reg(CFG_TAPS_LOW, lo);
    write_reg(CFG_TAPS_HIGH, hi);
  endtask

  function automatic logic [CFG_DAT_W-1:0] rand_taps();
    logic [CFG_DAT_W-1:0] t;
    case ($urandom_range(0, 4))
      0: t = '1;                        // saturates almost any line
      1: t = '0;
      2: for (int i = 0; i < 4; i++) t[16*i +: 16] = 16'($urandom_range(0, 16'h1400));
      default: t = {$urandom, $urandom};
    endcase
    return t;
  endfunction

  function automatic logic [RAD_W-1:0] rand_radius();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return RAD_W'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic int rand_len();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom_range(1, 8);    // short lines hit the border cases
      2:       return $urandom_range(21, 40);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  initial begin
    int sent;
    int phase;
    int len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: radius 1, zero border, all taps zero; single-pixel line
    send_px(8'hFF, 1'b1);
    drain();

    // widest kernel, every tap full scale, mirror border, line shorter than radius
    setup(3'd7, 1'b1, '1, '1);
    write_reg(CFG_SPARE, {$urandom, $urandom});
    send_px(8'hFF, 1'b0);
    send_px(8'h00, 1'b0);
    send_px(8'hAA, 1'b1);
    drain();

    // same short line length under zero border: no error flag
    write_reg(CFG_BORDER_MODE, '0);
    send_px(8'h55, 1'b0);
    send_px(8'hFF, 1'b0);
    send_px(8'h01, 1'b1);
    drain();

    // radius zero, center tap one half: exact halves round up
    setup(3'd0, 1'b0, 64'h0000_0000_0000_4000, '0);
    send_px(8'h01, 1'b0);
    send_px(8'hFE, 1'b0);
    send_px(8'h80, 1'b0);
    send_px(8'h7F, 1'b1);
    drain();

    // unity-gain kernel, mirror border; radius and mode changed partway through a line
    setup(3'd3, 1'b1, 64'h0400_0C00_1800_3000, {$urandom, $urandom});
    gap_max = 3;
    for (int i = 0; i < 8; i++) send_px(rand_px(), 1'b0);
    drain();
    write_reg(CFG_RADIUS, 64'd2);
    write_reg(CFG_BORDER_MODE, 64'd0);
    send_px(8'h00, 1'b0);
    send_px(8'hFF, 1'b0);
    send_px(rand_px(), 1'b1);
    drain();

    // random phases: new settings, a few lines each, drained in between
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      setup(rand_radius(), 1'($urandom_range(0, 1)), rand_taps(), rand_taps());
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE, 255)), {$urandom, $urandom});
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (phase == 2) begin
        // back-to-back pixels against a stalled receiver
        gap_max = 0;
        hold_off_req = 1'b1;
        send_line(60);
        sent += 60;
      end
      repeat ($urandom_range(2, 5)) begin
        len = rand_len();
        send_line(len);
        sent += len;
      end
      drain();
      phase++;
    end

    if (fail_count == 0) begin
      $display("** line_fir_convolution_border: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** line_fir_convolution_border: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
